// File: src/ssm_pkg.sv
// shared types and constants for the sorted set membership block
// no dependencies
package ssm_pkg;
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam int   VALUE_W   = 32;
endpackage

// File: src/sorted_set_membership.sv
// sorted set membership: table of signed values, merge sort on first query after loads,
// binary search per query; depends on ssm_pkg
// a load writes the table directly; the first query after loads first merge sorts the table
// (runs merged into scratch memory, then copied back) and then runs the binary search
// one request at a time: a new request is accepted only when idle, after the last result is taken
// reset: synchronous active low; clears entry count, sets sorted flag, memories left as is
module sorted_set_membership #(
    parameter int CAPACITY = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_req_type,
    input  logic signed [31:0]          s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_found,
    output logic                        m_status
);
    import ssm_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_PASS, S_MRD, S_MWAIT, S_MSEL, S_CRD, S_CWAIT, S_CWR,
        S_SRD, S_SWAIT, S_SCMP, S_OUT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg;
    logic sorted_reg;
    logic signed [31:0] key_reg;
    logic found_reg, status_reg;

    // merge pass pointers
    logic [CW-1:0] width_reg, lo_reg, mid_reg, hi_reg, a_reg, b_reg, k_reg;
    logic signed [31:0] va_reg, vb_reg;
    logic phase_reg;
    // search window
    logic [CW-1:0] slo_reg, shi_reg, smid_reg;

    logic signed [31:0] table_mem [CAPACITY];
    logic signed [31:0] scratch_mem [CAPACITY];
    logic signed [31:0] trd_reg, srd_reg;
    logic [AW-1:0] traddr, sraddr;
    logic signed [31:0] srd_dummy;

    logic [CW-1:0] span;
    assign span = ((count_reg - lo_reg - width_reg) > width_reg) ?
                  (lo_reg + (width_reg << 1)) : count_reg;

    always_comb begin
        traddr = a_reg[AW-1:0];
        if (state_reg == S_SWAIT) traddr = smid_reg[AW-1:0];
        else if (state_reg == S_MRD && phase_reg) traddr = b_reg[AW-1:0];
    end
    assign sraddr = k_reg[AW-1:0];

    always_ff @(posedge aclk) begin
        trd_reg <= table_mem[traddr];
        srd_reg <= scratch_mem[sraddr];
    end
    assign srd_dummy = srd_reg;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_found = found_reg;
    assign m_status = status_reg;

    logic a_live, b_live, take_a;
    assign a_live = a_reg < mid_reg;
    assign b_live = b_reg < hi_reg;
    assign take_a = a_live && (!b_live || va_reg < vb_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            sorted_reg <= 1'b1;
            phase_reg  <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_valid) begin
                    key_reg <= s_value;
                    found_reg <= 1'b0;
                    status_reg <= 1'b0;
                    if (s_req_type == REQ_LOAD) begin
                        if (count_reg < CW'(CAPACITY)) begin
                            table_mem[count_reg[AW-1:0]] <= s_value;
                            count_reg <= count_reg + 1'b1;
                            sorted_reg <= 1'b0;
                        end else status_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end else if (!sorted_reg) begin
                        width_reg <= CW'(1);
                        lo_reg <= '0;
                        state_reg <= S_PASS;
                    end else begin
                        slo_reg <= '0;
                        shi_reg <= count_reg;
                        state_reg <= S_SRD;
                    end
                end
                S_PASS: begin
                    // start next merge of runs, or next width, or done
                    if (width_reg >= count_reg) begin
                        sorted_reg <= 1'b1;
                        slo_reg <= '0;
                        shi_reg <= count_reg;
                        state_reg <= S_SRD;
                    end else if (lo_reg + width_reg >= count_reg) begin
                        width_reg <= width_reg << 1;
                        lo_reg <= '0;
                    end else begin
                        mid_reg <= lo_reg + width_reg;
                        hi_reg <= span;
                        a_reg <= lo_reg;
                        b_reg <= lo_reg + width_reg;
                        k_reg <= lo_reg;
                        phase_reg <= 1'b0;
                        state_reg <= S_MRD;
                    end
                end
                S_MRD: state_reg <= S_MWAIT;
                S_MWAIT: begin
                    if (!phase_reg) begin
                        va_reg <= trd_reg;
                        phase_reg <= 1'b1;
                        state_reg <= S_MRD;
                    end else begin
                        vb_reg <= trd_reg;
                        state_reg <= S_MSEL;
                    end
                end
                S_MSEL: begin
                    if (!a_live && !b_live) begin
                        k_reg <= lo_reg;
                        state_reg <= S_CRD;
                    end else begin
                        scratch_mem[k_reg[AW-1:0]] <= take_a ? va_reg : vb_reg;
                        k_reg <= k_reg + 1'b1;
                        if (take_a) begin
                            a_reg <= a_reg + 1'b1;
                            phase_reg <= 1'b0;
                        end else begin
                            b_reg <= b_reg + 1'b1;
                            phase_reg <= 1'b1;
                        end
                        state_reg <= S_MRD;
                    end
                end
                S_CRD: state_reg <= S_CWAIT;
                S_CWAIT: state_reg <= S_CWR;
                S_CWR: begin
                    // copy merged run back into the table
                    table_mem[k_reg[AW-1:0]] <= srd_dummy;
                    if (k_reg + 1'b1 >= hi_reg) begin
                        lo_reg <= lo_reg + (width_reg << 1);
                        state_reg <= S_PASS;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_CWAIT;
                    end
                end
                S_SRD: begin
                    if (slo_reg >= shi_reg) state_reg <= S_OUT;
                    else begin
                        smid_reg <= slo_reg + ((shi_reg - slo_reg) >> 1);
                        state_reg <= S_SWAIT;
                    end
                end
                S_SWAIT: state_reg <= S_SCMP;
                S_SCMP: begin
                    if (key_reg < trd_reg) begin
                        shi_reg <= smid_reg;
                        state_reg <= S_SRD;
                    end else if (trd_reg < key_reg) begin
                        slo_reg <= smid_reg + 1'b1;
                        state_reg <= S_SRD;
                    end else begin
                        found_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: if (m_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // a waiting result holds still until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_status));
    // input and result sides never open together
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid));
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY));
    // a dropped load never reports a hit
    a_drop_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_found);
`endif
endmodule

// File: dv/testbench.sv
// testbench for sorted_set_membership: directed table then random load/query traffic
// checks every result against a behavioural set model; depends on ssm_pkg and the rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ssm_pkg::*;

    localparam int DEPTH = 1024;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_req_type = REQ_LOAD;
    logic signed [31:0] s_value = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_found;
    logic               m_status;

    typedef struct packed {
        logic found;
        logic status;
    } answer_t;

    typedef struct {
        logic               kind;
        logic signed [31:0] val;
        logic               typed;
        answer_t            ans;
    } stim_row_t;

    // set model: membership does not depend on order, so the sort is not mirrored
    logic signed [31:0] stored_vals[$];
    answer_t            pending_answers[$];
    int                 error_count = 0;
    int                 answers_seen = 0;
    int                 loads_sent = 0;
    int                 queries_sent = 0;
    int                 hits_seen = 0;
    bit                 stim_done = 1'b0;

    sorted_set_membership #(.CAPACITY(DEPTH)) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req_type(s_req_type),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_found   (m_found),
        .m_status  (m_status)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic answer_t apply_item(logic kind, logic signed [31:0] val);
        answer_t a;
        a = '0;
        if (kind == REQ_LOAD) begin
            if (stored_vals.size() < DEPTH) stored_vals.push_back(val);
            else a.status = 1'b1;
        end else begin
            foreach (stored_vals[i]) if (stored_vals[i] == val) a.found = 1'b1;
        end
        return a;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // valid stays up between back to back transactions and drops only for a gap
    task automatic send_item(logic kind, logic signed [31:0] val, bit typed, answer_t want);
        answer_t got;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        got = apply_item(kind, val);
        if (typed && got != want)
            report_mismatch($sformatf("directed row disagrees with model for %0d", val));
        pending_answers.push_back(got);
        if (kind == REQ_LOAD) loads_sent++;
        else queries_sent++;
        s_valid <= 1'b1;
        s_req_type <= kind;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
    endtask

    // pick a value close to what is stored so queries hit often
    function automatic logic signed [31:0] near_value();
        logic signed [31:0] v;
        int r;
        r = $urandom_range(0, 9);
        if (stored_vals.size() > 0 && r < 5)
            v = stored_vals[$urandom_range(0, stored_vals.size() - 1)];
        else if (r < 8)
            v = $signed(32'($urandom_range(0, 63))) - 32;
        else
            v = $urandom;
        return v;
    endfunction

    // result side: random stalls, compare with oldest expectation
    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_valid && m_ready) begin
            answers_seen++;
            if (pending_answers.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = pending_answers.pop_front();
                if (m_found != want.found)
                    report_mismatch($sformatf("found %0b want %0b", m_found, want.found));
                if (m_status != want.status)
                    report_mismatch($sformatf("status %0b want %0b", m_status, want.status));
                if (m_found) hits_seen++;
            end
        end
        if (!aresetn) m_ready <= 1'b0;
        else if (answers_seen % 300 < 40) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 99) < 70) ? 1'b1 : ($urandom_range(0, 99) < 90);
    end

    initial begin
        stim_row_t rows[$];
        stim_row_t row;
        int burst;
        logic signed [31:0] v;

        // empty table, extremes, duplicates
        rows.push_back('{REQ_QUERY, 32'sd0, 1'b1, '{1'b0, 1'b0}});
        rows.push_back('{REQ_LOAD, 32'sh7fffffff, 1'b1, '{1'b0, 1'b0}});
        rows.push_back('{REQ_LOAD, 32'sh80000000, 1'b1, '{1'b0, 1'b0}});
        rows.push_back('{REQ_LOAD, 32'sd0, 1'b1, '{1'b0, 1'b0}});
        rows.push_back('{REQ_LOAD, -32'sd1, 1'b1, '{1'b0, 1'b0}});
        rows.push_back('{REQ_LOAD, 32'sd5, 1'b1, '{1'b0, 1'b0}});
        rows.push_back('{REQ_LOAD, 32'sd5, 1'b1, '{1'b0, 1'b0}});
        rows.push_back('{REQ_QUERY, 32'sh80000000, 1'b1, '{1'b1, 1'b0}});
        rows.push_back('{REQ_QUERY, 32'sh7fffffff, 1'b1, '{1'b1, 1'b0}});
        rows.push_back('{REQ_QUERY, 32'sd5, 1'b1, '{1'b1, 1'b0}});
        rows.push_back('{REQ_QUERY, 32'sd4, 1'b1, '{1'b0, 1'b0}});
        rows.push_back('{REQ_QUERY, -32'sd2, 1'b0, '{1'b0, 1'b0}});
        rows.push_back('{REQ_LOAD, 32'sh55555555, 1'b0, '{1'b0, 1'b0}});
        rows.push_back('{REQ_QUERY, 32'sh55555555, 1'b0, '{1'b0, 1'b0}});
        rows.push_back('{REQ_QUERY, 32'shaaaaaaaa, 1'b0, '{1'b0, 1'b0}});

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            row = rows[i];
            send_item(row.kind, row.val, row.typed, row.ans);
        end

        // random: bursts of loads then queries
        while (loads_sent + queries_sent < 1100) begin
            burst = $urandom_range(1, 40);
            repeat (burst) begin
                v = ($urandom_range(0, 3) == 0) ? $signed($urandom) : near_value();
                send_item(REQ_LOAD, v, 1'b0, '0);
            end
            burst = $urandom_range(1, 6);
            repeat (burst) send_item(REQ_QUERY, near_value(), 1'b0, '0);
        end
        // full table: dropped loads, then queries still answered
        while (stored_vals.size() < DEPTH) send_item(REQ_LOAD, $signed($urandom), 1'b0, '0);
        send_item(REQ_LOAD, 32'sd77, 1'b1, '{1'b0, 1'b1});
        send_item(REQ_LOAD, 32'sh80000000, 1'b1, '{1'b0, 1'b1});
        send_item(REQ_QUERY, 32'sd77, 1'b0, '0);
        repeat (10) send_item(REQ_QUERY, near_value(), 1'b0, '0);
        s_valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("covered %0d loads and %0d queries, %0d results, %0d hits",
                 loads_sent, queries_sent, answers_seen, hits_seen);
        $display("final table holds %0d entries", stored_vals.size());
        if (error_count == 0) $display("testbench: done, clean");
        else $display("testbench: done, errors");
        $finish;
    end

    // watchdog against a hang; the limit leaves room for sorts of a full table
    initial begin
        #400ms;
        $display("timeout with %0d results outstanding", pending_answers.size());
        $display("testbench: done, errors");
        $finish;
    end
endmodule
